// ----- sv/tmm_pkg.sv -----
// Shared types and constants for the tilt median mecanum drive mixer.
// Used by the sort cells, the sort chain, the mixing pipeline, the top level
// and the checker.
package tmm_pkg;

	// Field widths.
	localparam int ANGLE_W     = 9;
	localparam int DUTY_W      = 10;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_ADDR_W  = 3;

	// Default number of samples per block.
	localparam int BLOCK_SIZE_DEF = 5;

	// Register map: the register index is taken from paddr[2].
	localparam logic REG_DUTY_LIMIT = 1'b0;
	localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 10'd999;

	// Angle to command scaling: (x + 90) * 127 / 90 - 127.
	localparam int MAP_OFS  = 90;
	localparam int MAP_GAIN = 127;
	// Exact reciprocal for division by 90 of values below 2^16.
	localparam int DIV90_K  = 46604;
	localparam int DIV90_SH = 22;

	// Command to duty scaling: (v + 127) * 1000 / 127 - 1000.
	localparam int DUTY_GAIN = 1000;
	// Exact reciprocal for division by 127 of values below 2^20.
	localparam int DIV127_K  = 1056833;
	localparam int DIV127_SH = 27;
	localparam int DEAD_ZONE = 300;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	// What one sort cell hands to its right-hand neighbor.
	typedef struct packed {
		logic   gt;     // new sample goes at or left of this cell
		logic   valid;  // cell holds a sample
		angle_t value;
	} link_t;

	// One wheel command as it leaves the mixer.
	typedef struct packed {
		logic              fwd;
		logic [DUTY_W-1:0] duty;
	} wheel_cmd_t;

endpackage

// ----- sv/tmm_sort_cell.sv -----
// One cell of the insertion sorter: holds one sample of a block.
// Depends on tmm_pkg for link_t and angle_t.
module tmm_sort_cell import tmm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ins,
	input  logic   clear,
	input  angle_t x,
	input  link_t  prev,
	output link_t  next
);

	logic   valid_q;
	angle_t value_q;
	logic   gt;

	// An empty cell counts as larger than any sample.
	assign gt = !valid_q || (x < value_q);

	assign next.gt    = gt;
	assign next.valid = valid_q;
	assign next.value = value_q;

	// Occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (ins && gt) begin
			valid_q <= prev.gt ? prev.valid : 1'b1;
		end
	end

	// Sample: shift in from the left neighbor or take the new sample.
	always_ff @(posedge clk) begin
		if (ins && gt) begin
			value_q <= prev.gt ? prev.value : x;
		end
	end

endmodule

// ----- sv/tmm_sort_chain.sv -----
// Row of sort cells that keeps one block of samples in ascending order.
// Depends on tmm_pkg and tmm_sort_cell.
module tmm_sort_chain import tmm_pkg::*; #(
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ins,
	input  logic   clear,
	input  angle_t x,
	output angle_t median
);

	localparam int MID = BLOCK_SIZE / 2;

	link_t links [BLOCK_SIZE+1];

	// The left end never shifts anything in.
	assign links[0] = '{gt: 1'b0, valid: 1'b0, value: '0};

	for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
		tmm_sort_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ins   (ins),
			.clear (clear),
			.x     (x),
			.prev  (links[i]),
			.next  (links[i+1])
		);
	end

	assign median = links[MID+1].value;

endmodule

// ----- sv/tmm_mix_pipe.sv -----
// Scaling, mixing, dead zone and clamp of the two block medians.
// Depends on tmm_pkg for constants and wheel_cmd_t.
module tmm_mix_pipe import tmm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  angle_t            med_pitch,
	input  angle_t            med_roll,
	input  logic [DUTY_W-1:0] duty_limit,
	output logic              out_valid,
	output wheel_cmd_t        cmd_bd,
	output wheel_cmd_t        cmd_ca
);

	logic v_s2, v_s3, v_s4, v_s5, v_s6;

	// Stage 1: |x + 90| * 127 with its sign.
	logic signed [9:0] sum_p, sum_r;
	logic [9:0]        abs_p, abs_r;
	logic [15:0]       a_p_s2, a_r_s2;
	logic              neg_p_s2, neg_r_s2;

	assign sum_p = {med_pitch[ANGLE_W-1], med_pitch} + 10'(MAP_OFS);
	assign sum_r = {med_roll[ANGLE_W-1], med_roll} + 10'(MAP_OFS);
	assign abs_p = sum_p[9] ? 10'(-sum_p) : 10'(sum_p);
	assign abs_r = sum_r[9] ? 10'(-sum_r) : 10'(sum_r);

	always_ff @(posedge clk) begin
		a_p_s2   <= 16'(abs_p[8:0]) * 16'(MAP_GAIN);
		a_r_s2   <= 16'(abs_r[8:0]) * 16'(MAP_GAIN);
		neg_p_s2 <= sum_p[9];
		neg_r_s2 <= sum_r[9];
	end

	// Stage 2: divide the magnitude by 90 through the reciprocal.
	logic [31:0] prod_p, prod_r;
	logic [8:0]  q_p_s3, q_r_s3;
	logic        neg_p_s3, neg_r_s3;

	assign prod_p = 32'(a_p_s2) * 32'(DIV90_K);
	assign prod_r = 32'(a_r_s2) * 32'(DIV90_K);

	always_ff @(posedge clk) begin
		q_p_s3   <= prod_p[DIV90_SH+8:DIV90_SH];
		q_r_s3   <= prod_r[DIV90_SH+8:DIV90_SH];
		neg_p_s3 <= neg_p_s2;
		neg_r_s3 <= neg_r_s2;
	end

	// Stage 3: restore the sign, subtract 127, mix and offset by 127.
	logic signed [9:0]  qs_p, qs_r, mp, mr;
	logic signed [10:0] mix_bd, mix_ca, off_bd, off_ca;
	logic [10:0]        abs_bd, abs_ca;
	logic [9:0]         vmag_bd_s4, vmag_ca_s4;
	logic               neg_bd_s4, neg_ca_s4;

	assign qs_p   = {1'b0, q_p_s3};
	assign qs_r   = {1'b0, q_r_s3};
	assign mp     = (neg_p_s3 ? -qs_p : qs_p) - 10'(MAP_GAIN);
	assign mr     = (neg_r_s3 ? -qs_r : qs_r) - 10'(MAP_GAIN);
	assign mix_bd = {mr[9], mr} - {mp[9], mp};
	assign mix_ca = -{mp[9], mp} - {mr[9], mr};
	assign off_bd = mix_bd + 11'(MAP_GAIN);
	assign off_ca = mix_ca + 11'(MAP_GAIN);
	assign abs_bd = off_bd[10] ? 11'(-off_bd) : 11'(off_bd);
	assign abs_ca = off_ca[10] ? 11'(-off_ca) : 11'(off_ca);

	always_ff @(posedge clk) begin
		vmag_bd_s4 <= abs_bd[9:0];
		vmag_ca_s4 <= abs_ca[9:0];
		neg_bd_s4  <= off_bd[10];
		neg_ca_s4  <= off_ca[10];
	end

	// Stage 4: multiply the magnitude by 1000.
	logic [19:0] a_bd_s5, a_ca_s5;
	logic        neg_bd_s5, neg_ca_s5;

	always_ff @(posedge clk) begin
		a_bd_s5   <= 20'(vmag_bd_s4) * 20'(DUTY_GAIN);
		a_ca_s5   <= 20'(vmag_ca_s4) * 20'(DUTY_GAIN);
		neg_bd_s5 <= neg_bd_s4;
		neg_ca_s5 <= neg_ca_s4;
	end

	// Stage 5: divide by 127 through the reciprocal.
	logic [40:0] prod_bd, prod_ca;
	logic [12:0] q_bd_s6, q_ca_s6;
	logic        neg_bd_s6, neg_ca_s6;

	assign prod_bd = 41'(a_bd_s5) * 41'(DIV127_K);
	assign prod_ca = 41'(a_ca_s5) * 41'(DIV127_K);

	always_ff @(posedge clk) begin
		q_bd_s6   <= prod_bd[DIV127_SH+12:DIV127_SH];
		q_ca_s6   <= prod_ca[DIV127_SH+12:DIV127_SH];
		neg_bd_s6 <= neg_bd_s5;
		neg_ca_s6 <= neg_ca_s5;
	end

	// Stage 6: subtract 1000, apply the dead zone and the duty clamp.
	function automatic wheel_cmd_t shape(input logic [12:0] q, input logic neg,
			input logic [DUTY_W-1:0] lim);
		logic signed [13:0] qs;
		logic signed [13:0] p;
		logic signed [13:0] lims;
		logic [13:0]        mag;
		wheel_cmd_t         cmd;
		qs   = {1'b0, q};
		lims = {4'b0, lim};
		p    = (neg ? -qs : qs) - 14'(DUTY_GAIN);
		if (p < 14'(DEAD_ZONE) && p > -14'(DEAD_ZONE)) begin
			p = '0;
		end
		if (p > lims) begin
			p = lims;
		end
		if (p < -lims) begin
			p = -lims;
		end
		mag      = p[13] ? 14'(-p) : 14'(p);
		cmd.fwd  = !p[13];
		cmd.duty = mag[DUTY_W-1:0];
		return cmd;
	endfunction

	assign cmd_bd    = shape(q_bd_s6, neg_bd_s6, duty_limit);
	assign cmd_ca    = shape(q_ca_s6, neg_ca_s6, duty_limit);
	assign out_valid = v_s6;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

endmodule

// ----- sv/tilt_median_mecanum_drive_mixer.sv -----
// Result path: block end, flush, median capture register, mixer stages, output register, m_tvalid.
// Throughput: one sample beat per cycle, except that s_tready drops after each
// block's last beat while the medians are read out of the sort cells; a block's last
// beat waits while the previous result is still in the mixer or the output register.
// Reset: sort cells empty, sample count zero, duty_limit 999, no result pending.
module tilt_median_mecanum_drive_mixer import tmm_pkg::*; #(
	parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input beats
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // pitch_angle[8:0], roll_angle[17:9], zeros
	// Result beats
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // b_fwd, b_duty, c_fwd, c_duty, d_fwd,
	                                         // d_duty, a_fwd, a_duty, zeros
	// Configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int CNT_W = $clog2(BLOCK_SIZE);

	logic [DUTY_W-1:0] duty_limit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              flush_q;
	logic              busy_q;
	logic              in_beat, last_slot, out_beat;
	angle_t            pitch_in, roll_in, med_p, med_r;
	angle_t            med_p_s1, med_r_s1;
	logic              v_s1;
	logic              pipe_valid;
	wheel_cmd_t        cmd_bd, cmd_ca;
	logic              m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DUTY_LIMIT) ? 32'(duty_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q <= DUTY_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_DUTY_LIMIT) begin
			duty_limit_q <= pwdata[DUTY_W-1:0];
		end
	end

	// Input handshake and block counting.
	assign pitch_in  = s_tdata[ANGLE_W-1:0];
	assign roll_in   = s_tdata[2*ANGLE_W-1:ANGLE_W];
	assign last_slot = (cnt_q == CNT_W'(BLOCK_SIZE - 1));
	assign s_tready  = !flush_q && !(last_slot && busy_q);
	assign in_beat   = s_tvalid && s_tready;
	assign out_beat  = m_tvalid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			flush_q <= 1'b0;
			busy_q  <= 1'b0;
			v_s1    <= 1'b0;
		end else begin
			flush_q <= in_beat && last_slot;
			v_s1    <= flush_q;
			if (in_beat) begin
				cnt_q <= last_slot ? '0 : cnt_q + CNT_W'(1);
			end
			if (flush_q) begin
				busy_q <= 1'b1;
			end else if (out_beat) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Sorters for the two channels.
	tmm_sort_chain #(.BLOCK_SIZE(BLOCK_SIZE)) u_sort_pitch (
		.clk   (clk),
		.arst_n(arst_n),
		.ins   (in_beat),
		.clear (flush_q),
		.x     (pitch_in),
		.median(med_p)
	);

	tmm_sort_chain #(.BLOCK_SIZE(BLOCK_SIZE)) u_sort_roll (
		.clk   (clk),
		.arst_n(arst_n),
		.ins   (in_beat),
		.clear (flush_q),
		.x     (roll_in),
		.median(med_r)
	);

	// Capture the medians while the cells are cleared.
	always_ff @(posedge clk) begin
		if (flush_q) begin
			med_p_s1 <= med_p;
			med_r_s1 <= med_r;
		end
	end

	tmm_mix_pipe u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.med_pitch (med_p_s1),
		.med_roll  (med_r_s1),
		.duty_limit(duty_limit_q),
		.out_valid (pipe_valid),
		.cmd_bd    (cmd_bd),
		.cmd_ca    (cmd_ca)
	);

	// Output register; wheels B and D share one mix, C and A the other.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pipe_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (out_beat) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_valid) begin
			m_tdata_q <= {4'b0, cmd_ca.duty, cmd_ca.fwd, cmd_bd.duty, cmd_bd.fwd,
				cmd_ca.duty, cmd_ca.fwd, cmd_bd.duty, cmd_bd.fwd};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- sv/tmm_checker.sv -----
// Port-level checks for the tilt median mecanum drive mixer, bound to its top.
// Depends on tmm_pkg for the result width.
module tmm_checker import tmm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Wheels B and D, and wheels C and A, come from the same mix.
	a_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:0] == m_tdata[32:22] && m_tdata[21:11] == m_tdata[43:33])
		else $error("paired wheels disagree");

	// A reverse command on wheel B always has a nonzero duty.
	a_rev_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[10:1] != '0)
		else $error("reverse wheel with zero duty");

endmodule

bind tilt_median_mecanum_drive_mixer tmm_checker u_tmm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ----- dv/tb_tilt_median_mecanum_drive_mixer.sv -----
// Self-checking testbench for the tilt median mecanum drive mixer.
// Depends on tmm_pkg and the top level; it predicts each block's wheel commands
// from the accepted samples and checks every result beat against them.
module tb_tilt_median_mecanum_drive_mixer;
	import tmm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLK         = BLOCK_SIZE_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 16;
	localparam logic [CFG_ADDR_W-1:0] ADDR_DUTY_LIMIT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

	// Wheel order in a result beat, lowest bits first: B, C, D, A.
	typedef struct packed {
		logic [3:0]             fwd;
		logic [3:0][DUTY_W-1:0] duty;
	} wheel_set_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // pitch_angle[8:0], roll_angle[17:9], zeros
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // b_fwd, b_duty, c_fwd, c_duty, d_fwd,
	                                         // d_duty, a_fwd, a_duty, zeros
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr    = '0;
	logic [31:0]            pwdata   = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// Mirror of the block's state and the commands still owed by it.
	int          pitch_win [BLK];
	int          roll_win [BLK];
	int          samples_held;
	int          duty_limit_now;
	wheel_set_t  pending_wheels [$];

	int          errors;
	int          cycles;
	int          burst_left;
	rx_mode_t    rx_mode = RX_FREE;
	int          rx_left;
	string       wheel_name [4] = '{"B", "C", "D", "A"};

	tilt_median_mecanum_drive_mixer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Middle element of a block after an ascending sort.
	function automatic int block_median(input int v [BLK]);
		int s [BLK];
		int t;
		s = v;
		for (int i = 0; i < BLK - 1; i++)
			for (int j = 0; j < BLK - 1 - i; j++)
				if (s[j] > s[j+1]) begin
					t      = s[j];
					s[j]   = s[j+1];
					s[j+1] = t;
				end
		return s[BLK/2];
	endfunction

	// Degrees to a command, +-127 at +-90 degrees; SV signed division truncates toward zero.
	function automatic int angle_to_cmd(input int deg);
		return (deg + 90) * 254 / 180 - 127;
	endfunction

	// Command to a duty with dead zone and limit clamp.
	function automatic int cmd_to_duty(input int mix);
		int p;
		p = (mix + 127) * 2000 / 254 - 1000;
		if (p < 300 && p > -300)
			p = 0;
		if (p > duty_limit_now)
			p = duty_limit_now;
		if (p < -duty_limit_now)
			p = -duty_limit_now;
		return p;
	endfunction

	// Fold one accepted sample into the mirror; a full block owes one result.
	task automatic absorb_sample(input angle_t pitch, input angle_t roll);
		int         mp;
		int         mr;
		int         cmd [4];
		wheel_set_t w;
		pitch_win[samples_held] = pitch;
		roll_win[samples_held]  = roll;
		samples_held++;
		if (samples_held == BLK) begin
			samples_held = 0;
			mp     = angle_to_cmd(block_median(pitch_win));
			mr     = angle_to_cmd(block_median(roll_win));
			cmd[0] = cmd_to_duty(-mp + mr);
			cmd[1] = cmd_to_duty(-mp - mr);
			cmd[2] = cmd[0];
			cmd[3] = cmd[1];
			for (int k = 0; k < 4; k++) begin
				w.fwd[k]  = (cmd[k] >= 0);
				w.duty[k] = DUTY_W'(cmd[k] < 0 ? -cmd[k] : cmd[k]);
			end
			pending_wheels.push_back(w);
			for (int k = 0; k < BLK; k++) begin
				pitch_win[k] = 0;
				roll_win[k]  = 0;
			end
		end
	endtask

	// Offer one sample beat; the sender idles between bursts of random length.
	task automatic send_sample(input angle_t pitch, input angle_t roll);
		s_tdata  <= {{(IN_TDATA_W - 2*ANGLE_W){1'b0}}, roll, pitch};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		absorb_sample(pitch, roll);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(0, 12);
		end
	endtask

	task automatic send_block(input angle_t pitch [BLK], input angle_t roll [BLK]);
		for (int k = 0; k < BLK; k++)
			send_sample(pitch[k], roll[k]);
	endtask

	// Let every owed result leave, then give the pipeline time to empty.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_wheels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write: a setup phase, then the access phase until pready, then idle.
	task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_DUTY_LIMIT)
			duty_limit_now = int'(data[DUTY_W-1:0]);
		@(posedge clk);
	endtask

	// Register read, compared against the mirrored limit.
	task automatic cfg_check_limit();
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_DUTY_LIMIT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== 32'(duty_limit_now))
			report_mismatch($sformatf("duty_limit read %0d, expected %0d", got,
			                          duty_limit_now));
		@(posedge clk);
	endtask

	// Receiver readiness: switches between stall patterns every so often.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 160);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
			RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default:   m_tready <= ((cycles % 16) >= 12);
		endcase
	end

	// Result check: each accepted beat against the oldest owed command set.
	always @(posedge clk) begin : result_check
		wheel_set_t             want;
		logic                   got_fwd;
		logic [DUTY_W-1:0]      got_duty;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_wheels.size() == 0) begin
				report_mismatch($sformatf("result beat with none owed: %h", m_tdata));
			end else begin
				want = pending_wheels.pop_front();
				for (int k = 0; k < 4; k++) begin
					got_fwd  = m_tdata[k*(DUTY_W+1)];
					got_duty = m_tdata[k*(DUTY_W+1)+1 +: DUTY_W];
					if (got_fwd !== want.fwd[k])
						report_mismatch($sformatf("wheel %s forward %b, expected %b",
						                          wheel_name[k], got_fwd, want.fwd[k]));
					if (got_duty !== want.duty[k])
						report_mismatch($sformatf("wheel %s duty %0d, expected %0d",
						                          wheel_name[k], got_duty, want.duty[k]));
				end
			end
		end
	end

	// Mostly moderate tilts, with full-range patterns and corners mixed in.
	function automatic angle_t pick_angle();
		int corner [8] = '{-256, 255, -180, 180, -91, -90, 90, 0};
		int sel;
		int v;
		sel = $urandom_range(0, 9);
		if (sel <= 5)
			v = $urandom_range(0, 240) - 120;
		else if (sel <= 7)
			v = $urandom_range(0, 360) - 180;
		else if (sel == 8)
			v = $urandom_range(0, 511) - 256;
		else
			v = corner[$urandom_range(0, 7)];
		return angle_t'(v);
	endfunction

	// Default limit, field extremes and truncation of angles below -90.
	task automatic test_defaults_and_corners();
		cfg_check_limit();
		send_block('{-91, -95, -100, -93, -120}, '{-256, 255, 180, -180, 0});
		send_block('{255, -256, 180, -180, 17}, '{-91, -95, -100, -93, -120});
		drain_results();
	endtask

	// Limit above 999, at zero, below the dead zone, and an unmapped write.
	task automatic test_duty_limit_settings();
		cfg_write(ADDR_DUTY_LIMIT, 32'hFFFF_FFFF);
		cfg_check_limit();
		send_block('{-180, -170, -175, -160, -179}, '{180, 170, 160, 175, 179});
		drain_results();
		cfg_write(ADDR_DUTY_LIMIT, 32'd0);
		cfg_check_limit();
		send_block('{170, 160, 175, 150, 180}, '{-170, -160, -175, -150, -180});
		drain_results();
		cfg_write(ADDR_DUTY_LIMIT, 32'd250);
		cfg_write(ADDR_UNMAPPED, 32'd5);
		cfg_check_limit();
		send_block('{-150, -150, -150, -150, -150}, '{0, 0, 0, 0, 0});
		drain_results();
	endtask

	// Random samples in phases, each under a newly written limit.
	task automatic test_random_traffic();
		int          n_items;
		logic [31:0] limit;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       limit = 32'd1023;
				1:       limit = 32'd0;
				2:       limit = $urandom_range(1, 299);
				3:       limit = $urandom_range(300, 998);
				4:       limit = 32'd999;
				default: limit = $urandom_range(0, 1023);
			endcase
			limit = ($urandom() & ~32'h3FF) | limit;
			cfg_write(ADDR_DUTY_LIMIT, limit);
			if ($urandom_range(0, 1) == 1)
				cfg_write(ADDR_UNMAPPED, $urandom());
			cfg_check_limit();
			n_items = $urandom_range(205, 270);
			for (int k = 0; k < n_items; k++)
				send_sample(pick_angle(), pick_angle());
			drain_results();
		end
	endtask

	initial begin
		errors         = 0;
		samples_held   = 0;
		duty_limit_now = int'(DUTY_LIMIT_RST);
		burst_left     = 0;
		for (int k = 0; k < BLK; k++) begin
			pitch_win[k] = 0;
			roll_win[k]  = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_and_corners();
		test_duty_limit_settings();
		test_random_traffic();

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- tilt_median_mecanum_drive_mixer.f -----
sv/tmm_pkg.sv
sv/tmm_sort_cell.sv
sv/tmm_sort_chain.sv
sv/tmm_mix_pipe.sv
sv/tilt_median_mecanum_drive_mixer.sv
sv/tmm_checker.sv
dv/tb_tilt_median_mecanum_drive_mixer.sv
